/* sv/partition_nonneg_sort_neg_desc_assert.svh */
// Assertion macros for the partition and sort block.
`ifndef PARTITION_NONNEG_SORT_NEG_DESC_ASSERT_SVH
`define PARTITION_NONNEG_SORT_NEG_DESC_ASSERT_SVH

`ifndef SYNTH
// Check that a property holds on every clock edge outside reset.
`define PNS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a cause is followed by its effect in the next cycle.
`define PNS_ASSERT_NEXT(name, clk, rst, cause, effect, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);
`else
`define PNS_ASSERT(name, clk, rst, prop, msg)
`define PNS_ASSERT_NEXT(name, clk, rst, cause, effect, msg)
`endif

`endif

/* sv/pns_pkg.sv */
// Shared types, sizes and microcode definitions for the partition and sort block.
package pns_pkg;

   localparam int MAX_LEN = 64;
   localparam int DATA_W  = 32;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int UPC_W   = 4;

   typedef logic [UPC_W-1:0] upc_type;

   // Program steps
   localparam upc_type STEP_LOAD      = upc_type'(0);
   localparam upc_type STEP_INIT      = upc_type'(1);
   localparam upc_type STEP_NEG_START = upc_type'(2);
   localparam upc_type STEP_NEG_READ  = upc_type'(3);
   localparam upc_type STEP_NEG_CMP   = upc_type'(4);
   localparam upc_type STEP_NEG_TEST  = upc_type'(5);
   localparam upc_type STEP_NEG_EMIT  = upc_type'(6);
   localparam upc_type STEP_NEG_LOOP  = upc_type'(7);
   localparam upc_type STEP_POS_START = upc_type'(8);
   localparam upc_type STEP_POS_READ  = upc_type'(9);
   localparam upc_type STEP_POS_EMIT  = upc_type'(10);
   localparam upc_type STEP_FINISH    = upc_type'(11);

   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_LOAD       = 3'd1,
      OP_INIT       = 3'd2,
      OP_PASS_START = 3'd3,
      OP_CMP_NEG    = 3'd4,
      OP_EMIT_NEG   = 3'd5,
      OP_EMIT_POS   = 3'd6,
      OP_FINISH     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE    = 2'd0,
      HOLD_REQ     = 2'd1,
      HOLD_OUT     = 2'd2,
      HOLD_POS_OUT = 2'd3
   } hold_type;

   typedef enum logic [2:0] {
      JMP_NEVER     = 3'd0,
      JMP_ALWAYS    = 3'd1,
      JMP_NOT_LAST  = 3'd2,
      JMP_MORE      = 3'd3,
      JMP_NOT_FOUND = 3'd4,
      JMP_MULT_MORE = 3'd5
   } jump_type;

   typedef struct packed {
      op_type   op;
      hold_type hold_on;
      jump_type jump;
      upc_type  target;
   } ucode_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      op_type op;
      logic   go;
   } ctrl_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic req_valid;
      logic req_last;
      logic more;
      logic found;
      logic mult_last;
      logic out_free;
      logic data_neg;
   } status_type;

endpackage

/* sv/pns_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pns_datapath.sv */
// Datapath: element store, scan registers, best-value tracking and result register.
module pns_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pns_pkg::ctrl_type                 ctrl,
   output pns_pkg::status_type               status,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pns_pkg::DATA_W-1:0] req_value,
   input  logic                              req_is_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pns_pkg::DATA_W-1:0] rsp_value_out,
   output logic                              rsp_last_out,
   output logic                              rsp_overflow
);
   import pns_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic              have_thr_ff, have_thr_in;
   logic [DATA_W-1:0] thr_ff, thr_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]  mult_ff, mult_in;
   logic [CNT_W-1:0]  emitted_ff, emitted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              store_en;
   logic              room;
   logic [DATA_W-1:0] rd_data;
   logic              data_neg;
   logic              out_free;
   logic              candidate;
   logic              push;
   logic [DATA_W-1:0] push_value;

   // Element store
   pns_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign room      = count_ff < CNT_W'(MAX_LEN);
   assign store_en  = ctrl.go && (ctrl.op == OP_LOAD) && room;
   assign data_neg  = rd_data[DATA_W-1];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (ctrl.op != OP_LOAD);

   // Negative below the last emitted value is a candidate for this pass
   assign candidate = data_neg &&
                      (!have_thr_ff || ($signed(rd_data) < $signed(thr_ff)));

   // Select what goes to the result register
   assign push = ctrl.go && ((ctrl.op == OP_EMIT_NEG) ||
                             ((ctrl.op == OP_EMIT_POS) && !data_neg));
   assign push_value = (ctrl.op == OP_EMIT_NEG) ? best_ff : rd_data;

   // Status toward the sequencer
   always_comb begin
      status.req_valid = req_valid;
      status.req_last  = req_is_last;
      status.more      = (addr_ff + CNT_W'(1)) != count_ff;
      status.found     = found_ff;
      status.mult_last = mult_ff == CNT_W'(1);
      status.out_free  = out_free;
      status.data_neg  = data_neg;
   end

   // Next state of the working registers
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      addr_in     = addr_ff;
      have_thr_in = have_thr_ff;
      thr_in      = thr_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      mult_in     = mult_ff;
      emitted_in  = emitted_ff;
      if (ctrl.go) begin
         case (ctrl.op)
            OP_LOAD: begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            OP_INIT: begin
               have_thr_in = 1'b0;
               emitted_in  = '0;
            end
            OP_PASS_START: begin
               addr_in  = '0;
               found_in = 1'b0;
               mult_in  = '0;
            end
            OP_CMP_NEG: begin
               addr_in = addr_ff + CNT_W'(1);
               if (candidate) begin
                  if (!found_ff || ($signed(rd_data) > $signed(best_ff))) begin
                     best_in  = rd_data;
                     mult_in  = CNT_W'(1);
                     found_in = 1'b1;
                  end else if (rd_data == best_ff) begin
                     mult_in = mult_ff + CNT_W'(1);
                  end
               end
            end
            OP_EMIT_NEG: begin
               mult_in    = mult_ff - CNT_W'(1);
               emitted_in = emitted_ff + CNT_W'(1);
               if (mult_ff == CNT_W'(1)) begin
                  thr_in      = best_ff;
                  have_thr_in = 1'b1;
               end
            end
            OP_EMIT_POS: begin
               addr_in = addr_ff + CNT_W'(1);
               if (!data_neg) begin
                  emitted_in = emitted_ff + CNT_W'(1);
               end
            end
            OP_FINISH: begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Result register: load on push, drop after transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = push_value;
         rsp_last_in  = (emitted_ff + CNT_W'(1)) == count_ff;
         rsp_ovf_in   = ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         have_thr_ff  <= 1'b0;
         found_ff     <= 1'b0;
         mult_ff      <= '0;
         emitted_ff   <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         have_thr_ff  <= have_thr_in;
         found_ff     <= found_in;
         mult_ff      <= mult_in;
         emitted_ff   <= emitted_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      thr_ff       <= thr_in;
      best_ff      <= best_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

/* sv/pns_ucode_rom.sv */
// Microcode table: one control word per program step.
module pns_ucode_rom (
   input  pns_pkg::upc_type   upc,
   output pns_pkg::ucode_type word
);
   import pns_pkg::*;

   // Decode the step into its control word
   always_comb begin
      unique case (upc)
         STEP_LOAD:      word = '{OP_LOAD,       HOLD_REQ,     JMP_NOT_LAST,  STEP_LOAD};
         STEP_INIT:      word = '{OP_INIT,       HOLD_NONE,    JMP_NEVER,     STEP_LOAD};
         STEP_NEG_START: word = '{OP_PASS_START, HOLD_NONE,    JMP_NEVER,     STEP_LOAD};
         STEP_NEG_READ:  word = '{OP_NONE,       HOLD_NONE,    JMP_NEVER,     STEP_LOAD};
         STEP_NEG_CMP:   word = '{OP_CMP_NEG,    HOLD_NONE,    JMP_MORE,      STEP_NEG_READ};
         STEP_NEG_TEST:  word = '{OP_NONE,       HOLD_NONE,    JMP_NOT_FOUND, STEP_POS_START};
         STEP_NEG_EMIT:  word = '{OP_EMIT_NEG,   HOLD_OUT,     JMP_MULT_MORE, STEP_NEG_EMIT};
         STEP_NEG_LOOP:  word = '{OP_NONE,       HOLD_NONE,    JMP_ALWAYS,    STEP_NEG_START};
         STEP_POS_START: word = '{OP_PASS_START, HOLD_NONE,    JMP_NEVER,     STEP_LOAD};
         STEP_POS_READ:  word = '{OP_NONE,       HOLD_NONE,    JMP_NEVER,     STEP_LOAD};
         STEP_POS_EMIT:  word = '{OP_EMIT_POS,   HOLD_POS_OUT, JMP_MORE,      STEP_POS_READ};
         STEP_FINISH:    word = '{OP_FINISH,     HOLD_NONE,    JMP_ALWAYS,    STEP_LOAD};
         default:        word = '{OP_FINISH,     HOLD_NONE,    JMP_ALWAYS,    STEP_LOAD};
      endcase
   end

endmodule

/* sv/pns_sequencer.sv */
// Step counter with hold and conditional jump over the microcode table.
module pns_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  pns_pkg::status_type status,
   output pns_pkg::ctrl_type   ctrl,
   output pns_pkg::upc_type    upc
);
   import pns_pkg::*;

   upc_type   upc_ff, upc_in;
   ucode_type word;
   logic      go;
   logic      take_jump;

   pns_ucode_rom u_rom (
      .upc  (upc_ff),
      .word (word)
   );

   // Hold on the step until its condition is met
   always_comb begin
      case (word.hold_on)
         HOLD_NONE:    go = 1'b1;
         HOLD_REQ:     go = status.req_valid;
         HOLD_OUT:     go = status.out_free;
         HOLD_POS_OUT: go = status.data_neg || status.out_free;
         default:      go = 1'b1;
      endcase
   end

   // Evaluate the jump condition
   always_comb begin
      case (word.jump)
         JMP_NEVER:     take_jump = 1'b0;
         JMP_ALWAYS:    take_jump = 1'b1;
         JMP_NOT_LAST:  take_jump = !status.req_last;
         JMP_MORE:      take_jump = status.more;
         JMP_NOT_FOUND: take_jump = !status.found;
         JMP_MULT_MORE: take_jump = !status.mult_last;
         default:       take_jump = 1'b0;
      endcase
   end

   // Advance, jump or hold
   always_comb begin
      if (!go) begin
         upc_in = upc_ff;
      end else if (take_jump) begin
         upc_in = word.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl.op = word.op;
   assign ctrl.go = go;
   assign upc     = upc_ff;

endmodule

/* sv/partition_nonneg_sort_neg_desc.sv */
// Load: one transfer per cycle while the block waits for the marked last item.
// After the last item, the run scans the store RAM once per distinct negative value and emits its copies,
// largest first, then scans once more without a find, then scans for the non-negatives in arrival order;
// the next vector loads after the run.
// Reset is synchronous, active high; it empties the store and clears overflow.
`include "partition_nonneg_sort_neg_desc_assert.svh"

module partition_nonneg_sort_neg_desc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pns_pkg::DATA_W-1:0] req_value,
   input  logic                              req_is_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pns_pkg::DATA_W-1:0] rsp_value_out,
   output logic                              rsp_last_out,
   output logic                              rsp_overflow
);
   import pns_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   upc_type    upc;

   pns_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .upc    (upc)
   );

   pns_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_last_out  (rsp_last_out),
      .rsp_overflow  (rsp_overflow)
   );

   // Input is open only on the load step
   `PNS_ASSERT(a_stall_load, clock, reset, !req_stall |-> (upc == STEP_LOAD), "input open off load step")
   // A negative is emitted only after a pass found one
   `PNS_ASSERT(a_emit_found, clock, reset, (ctrl.op == OP_EMIT_NEG) |-> status.found, "emit without found value")
   // A new result never starts from the load step
   `PNS_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(upc != STEP_LOAD), "result pushed while loading")
   // Finishing a run returns to loading
   `PNS_ASSERT_NEXT(a_finish_load, clock, reset, ctrl.op == OP_FINISH, upc == STEP_LOAD, "finish did not return to load")

endmodule

/* test/partition_nonneg_sort_neg_desc_tb.sv */
// Testbench for the partition and sort block: vectors of signed words, results checked in order.
`timescale 1ns / 1ps

module partition_nonneg_sort_neg_desc_tb;

   typedef logic signed [pns_pkg::DATA_W-1:0] word_t;

   typedef struct {
      word_t value;
      bit    last;
      bit    overflow;
   } run_word_t;

   // Predicts the rearranged run and checks each result against it
   class rearrange_book;
      word_t     held_words[$];
      bit        dropped;
      run_word_t due_words[$];
      int        errors;

      function new();
         dropped = 0;
         errors  = 0;
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      function int pending();
         return due_words.size();
      endfunction

      // Store or drop the word; on the last one, build the whole run
      function void note_input(word_t v, bit last);
         word_t     negs[$];
         run_word_t r;
         int        j;
         if (held_words.size() < pns_pkg::MAX_LEN)
            held_words.push_back(v);
         else
            dropped = 1;
         if (!last)
            return;
         // insert negatives in descending order
         foreach (held_words[i]) begin
            if (held_words[i] < 0) begin
               j = 0;
               while (j < negs.size() && negs[j] >= held_words[i])
                  j++;
               negs.insert(j, held_words[i]);
            end
         end
         foreach (negs[i]) begin
            r.value    = negs[i];
            r.last     = 0;
            r.overflow = dropped;
            due_words.push_back(r);
         end
         // non-negatives keep arrival order
         foreach (held_words[i]) begin
            if (held_words[i] >= 0) begin
               r.value    = held_words[i];
               r.last     = 0;
               r.overflow = dropped;
               due_words.push_back(r);
            end
         end
         if (due_words.size() > 0)
            due_words[due_words.size() - 1].last = 1;
         held_words.delete();
         dropped = 0;
      endfunction

      task check_result(word_t v, bit last, bit ovf);
         run_word_t e;
         if (due_words.size() == 0) begin
            report($sformatf("result %0d with nothing due", v));
            return;
         end
         e = due_words.pop_front();
         if (v !== e.value)
            report($sformatf("value %0d, want %0d", v, e.value));
         if (last !== e.last)
            report($sformatf("last flag %b, want %b on value %0d", last, e.last, e.value));
         if (ovf !== e.overflow)
            report($sformatf("overflow %b, want %b on value %0d", ovf, e.overflow, e.value));
      endtask
   endclass

   logic  clock = 1'b0;
   logic  reset = 1'b1;
   logic  req_valid = 1'b0;
   logic  req_stall;
   word_t req_value = '0;
   logic  req_is_last = 1'b0;
   logic  rsp_valid;
   logic  rsp_stall = 1'b0;
   word_t rsp_value_out;
   logic  rsp_last_out;
   logic  rsp_overflow;

   rearrange_book book = new();
   bit            quiet_sender = 0;
   bit            quiet_receiver = 0;

   word_t tie_pool[4] = '{-32'sd5, -32'sd100000, 32'sd3, word_t'(32'h8000_0001)};

   partition_nonneg_sort_neg_desc dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_last_out  (rsp_last_out),
      .rsp_overflow  (rsp_overflow)
   );

   always #5 clock = ~clock;

   // Mix full-range words with small values, extremes and repeats for ties
   function automatic word_t draw_word();
      case ($urandom_range(0, 5))
         1: return word_t'($signed($urandom_range(0, 15)) - 8);
         2: begin
            case ($urandom_range(0, 4))
               0: return word_t'(32'h8000_0000);
               1: return word_t'(32'h7fff_ffff);
               2: return '0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         3: return tie_pool[$urandom_range(0, 3)];
         default: return word_t'($urandom);
      endcase
   endfunction

   // Offer one word after a random gap and hold it until the transfer
   task automatic send_item(input word_t v, input bit last);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      book.note_input(v, last);
   endtask

   task automatic send_run(input word_t words[$]);
      quiet_sender = ($urandom_range(0, 3) == 0);
      foreach (words[i])
         send_item(words[i], i == words.size() - 1);
   endtask

   // Drive the input side: directed vectors, then random ones
   initial begin : stimulus
      word_t run[$];
      int    sent;
      int    vec;
      int    len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run = '{32'sd0};
      send_run(run);
      run = '{word_t'(32'h8000_0000)};
      send_run(run);
      run = '{word_t'(32'h7fff_ffff), -32'sd1, 32'sd0, word_t'(32'h8000_0000),
              32'sd1, -32'sd1, 32'sd5, -32'sd7};
      send_run(run);
      // all negative, with a tie
      run = '{-32'sd3, -32'sd10, -32'sd3, -32'sd1};
      send_run(run);
      // all non-negative, with repeats
      run = '{32'sd7, 32'sd0, 32'sd7, word_t'(32'h7fff_ffff)};
      send_run(run);
      run = '{32'sd3, -32'sd4};
      send_run(run);

      sent = 0;
      vec  = 0;
      while (sent < 360) begin
         if (vec == 4)
            len = pns_pkg::MAX_LEN;
         else if (vec == 9)
            len = pns_pkg::MAX_LEN + 3;
         else if ($urandom_range(0, 29) == 0)
            len = $urandom_range(pns_pkg::MAX_LEN - 1, pns_pkg::MAX_LEN + 4);
         else
            len = $urandom_range(1, 10);
         run.delete();
         repeat (len)
            run.push_back(draw_word());
         send_run(run);
         sent += len;
         vec++;
      end
      req_valid <= 1'b0;

      // drain the remaining results, then allow a short tail
      while (book.pending() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (book.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Accept results with random stalls and one long hold-off
   initial begin : rsp_side
      int wait_left;
      int taken;
      bit held_long;
      wait_left = 0;
      taken     = 0;
      held_long = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            book.check_result(rsp_value_out, rsp_last_out, rsp_overflow);
            taken++;
            if (taken % 16 == 0)
               quiet_receiver = ($urandom_range(0, 3) == 0);
            wait_left = quiet_receiver ? 0 : $urandom_range(0, 5);
            if (taken == 40 && !held_long) begin
               wait_left = 400;
               held_long = 1;
            end
         end else if (wait_left > 0) begin
            wait_left--;
         end
         rsp_stall <= (wait_left > 0);
      end
   end

   // Stop a hung run
   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* partition_nonneg_sort_neg_desc.f */
+incdir+sv
sv/pns_pkg.sv
sv/pns_ram.sv
sv/pns_datapath.sv
sv/pns_ucode_rom.sv
sv/pns_sequencer.sv
sv/partition_nonneg_sort_neg_desc.sv
test/partition_nonneg_sort_neg_desc_tb.sv
